>>> sv/dtd_pkg.sv
// dtd_pkg: shared types and constants for the identifier octet decoder
// used by der_tag_decoder_compare_core; no dependencies
package dtd_pkg;

    localparam int unsigned TAG_W   = 32;
    localparam int unsigned OCTET_W = 8;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_EXPECTED_CLASS       = 2'd0;
    localparam cfg_idx_t REG_EXPECTED_CONSTRUCTED = 2'd1;
    localparam cfg_idx_t REG_EXPECTED_TAG         = 2'd2;

    localparam logic [4:0] SHORT_TAG_ESCAPE = 5'h1F;
    localparam logic [7:0] LEAD_MASK        = 8'hF0;
    localparam logic [7:0] LEAD_NARROW      = 8'h80;

    // subsequent octet count, saturating
    localparam logic [2:0] COUNT_MAX   = 3'd6;
    localparam logic [2:0] COUNT_LIMIT = 3'd5;

    typedef struct packed {
        logic [1:0]       tag_class;
        logic             is_constructed;
        logic [TAG_W-1:0] tag_number;
        logic             too_large;
        logic             matches_res;
    } result_t;

endpackage

>>> sv/der_tag_decoder_compare_core.sv
// der_tag_decoder_compare_core: identifier octet decoder with compare
// a result is written to the result register, with out_valid set, when its last octet leaves the octet register
// throughput: one octet per cycle while out_stall does not hold back an octet that yields a result,
// set by the single decode stage between the octet register and the result register
// reset: rst_n clears the decode state, the expected-value registers
// and both valid flags; payload registers are not reset
module der_tag_decoder_compare_core
    import dtd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 wr_en,
    input  cfg_idx_t             wr_index,
    input  logic [CFG_W-1:0]     wr_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OCTET_W-1:0]   octet,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           tag_class,
    output logic                 is_constructed,
    output logic [TAG_W-1:0]     tag_number,
    output logic                 too_large,
    output logic                 matches_res
);

    // configuration
    logic [1:0]       exp_class_reg;
    logic             exp_cons_reg;
    logic [TAG_W-1:0] exp_tag_reg;

    // input stage
    logic               s1_valid_reg;
    logic [OCTET_W-1:0] s1_octet_reg;

    // decode state
    logic             long_form_reg,  long_form_next;
    logic [1:0]       held_class_reg, held_class_next;
    logic             held_cons_reg,  held_cons_next;
    logic [2:0]       count_reg,      count_next;
    logic             wide_reg,       wide_next;
    logic [TAG_W-1:0] acc_reg,        acc_next;

    // result stage
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t res;

    logic s1_emit;
    logic s1_go;
    logic out_free;
    logic big;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_class_reg <= '0;
            exp_cons_reg  <= 1'b0;
            exp_tag_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_EXPECTED_CLASS:       exp_class_reg <= wr_data[1:0];
                REG_EXPECTED_CONSTRUCTED: exp_cons_reg  <= wr_data[0];
                REG_EXPECTED_TAG:         exp_tag_reg   <= wr_data[TAG_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    // a word that yields no result never waits on the output side
    assign s1_go    = s1_valid_reg && (!s1_emit || out_free);
    assign in_stall = s1_valid_reg && !s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_octet_reg <= octet;
        end
    end

    always_comb
    begin
        long_form_next  = long_form_reg;
        held_class_next = held_class_reg;
        held_cons_next  = held_cons_reg;
        count_next      = count_reg;
        wide_next       = wide_reg;
        acc_next        = acc_reg;
        s1_emit         = 1'b0;
        big             = 1'b0;
        res             = '0;

        if (!long_form_reg)
        begin
            held_class_next = s1_octet_reg[7:6];
            held_cons_next  = s1_octet_reg[5];
            if (s1_octet_reg[4:0] != SHORT_TAG_ESCAPE)
            begin
                s1_emit            = 1'b1;
                res.tag_class      = s1_octet_reg[7:6];
                res.is_constructed = s1_octet_reg[5];
                res.tag_number     = {{(TAG_W-5){1'b0}}, s1_octet_reg[4:0]};
            end
            else
            begin
                long_form_next = 1'b1;
                count_next     = '0;
                wide_next      = 1'b0;
                acc_next       = '0;
            end
        end
        else
        begin
            if (count_reg < COUNT_MAX)
            begin
                count_next = count_reg + 3'd1;
            end
            if (count_next == 3'd1)
            begin
                wide_next = (s1_octet_reg & LEAD_MASK) != LEAD_NARROW;
            end
            acc_next = {acc_reg[TAG_W-8:0], s1_octet_reg[6:0]};

            if (!s1_octet_reg[7])
            begin
                s1_emit        = 1'b1;
                long_form_next = 1'b0;
                big = (count_next > COUNT_LIMIT) ||
                      ((count_next == COUNT_LIMIT) && wide_next);
                res.tag_class      = held_class_reg;
                res.is_constructed = held_cons_reg;
                res.tag_number     = big ? '0 : acc_next;
                res.too_large      = big;
            end
        end

        res.matches_res = !res.too_large &&
                          (res.tag_class == exp_class_reg) &&
                          (res.is_constructed == exp_cons_reg) &&
                          (res.tag_number == exp_tag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_form_reg  <= 1'b0;
            held_class_reg <= '0;
            held_cons_reg  <= 1'b0;
            count_reg      <= '0;
            wide_reg       <= 1'b0;
            acc_reg        <= '0;
        end
        else if (s1_go)
        begin
            long_form_reg  <= long_form_next;
            held_class_reg <= held_class_next;
            held_cons_reg  <= held_cons_next;
            count_reg      <= count_next;
            wide_reg       <= wide_next;
            acc_reg        <= acc_next;
        end
    end

    always_comb
    begin
        if (s1_go && s1_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tag_class      = out_reg.tag_class;
    assign is_constructed = out_reg.is_constructed;
    assign tag_number     = out_reg.tag_number;
    assign too_large      = out_reg.too_large;
    assign matches_res    = out_reg.matches_res;

endmodule
